// ===== rtl/core/acl_pkg.sv =====
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types, byte codes and keyword tables for the command line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

  // Number of keywords and the widest keyword slot (power of two for indexing)
  localparam int KW_COUNT      = 6;
  localparam int KW_SLOTS      = 16;
  localparam int KW_POS_W      = $clog2(KW_SLOTS);

  localparam int BUFFER_DEPTH_DEF = 256;

  localparam int          LEN_W   = 9;
  localparam int unsigned LEN_MAX = 511;

  localparam logic [7:0] BYTE_PLUS = 8'h2B;
  localparam logic [7:0] BYTE_CR   = 8'h0D;

  typedef enum logic [2:0] {
    CMD_NUMTEST   = 3'd0,
    CMD_STARTBURN = 3'd1,
    CMD_ENDBURN   = 3'd2,
    CMD_BURNHEX   = 3'd3,
    CMD_APP       = 3'd4,
    CMD_AT        = 3'd5,
    CMD_UNKNOWN   = 3'd6
  } cmd_code_t;

  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // Keyword characters, padded with zero beyond each keyword's length
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{"+", "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "1", "2", "3",
      8'h00, 8'h00},
    '{"+", "S", "T", "A", "R", "T", "B", "U", "R", "N", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{"+", "E", "N", "D", "B", "U", "R", "N", 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "B", "U", "R", "N", "H", "E", "X", "=", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "A", "P", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "A", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [KW_POS_W:0] KW_LEN [KW_COUNT] = '{
    5'd14, 5'd10, 5'd8, 5'd9, 5'd4, 5'd3
  };

  // Prefix match status passed from the matcher to the line control
  typedef struct packed {
    kw_mask_t  alive_nxt;
    cmd_code_t code;
  } acl_match_t;

endpackage

`default_nettype wire

// ===== rtl/core/acl_if.sv =====
// ----------------------------------------------------------------------------
// acl_if
// Valid/ready channels for received bytes and classification results.
// ----------------------------------------------------------------------------
`default_nettype none

interface acl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command_code;
  logic       reply_ok;
  logic [8:0] line_length;

  modport source (output valid, output command_code, output reply_ok,
                  output line_length, input ready);
  modport sink   (input valid, input command_code, input reply_ok,
                  input line_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acl_matcher.sv =====
// ----------------------------------------------------------------------------
// acl_matcher
// Per-keyword prefix comparison of one stored byte and priority classify.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_matcher
  import acl_pkg::*;
#(
  parameter int CNT_W = 9
) (
  input  wire logic [CNT_W-1:0] pos,
  input  wire logic [7:0]       rx_byte,
  input  wire kw_mask_t         alive,
  output acl_match_t            status
);

  logic                pos_low;
  logic [KW_POS_W-1:0] slot;
  kw_mask_t            alive_nxt;
  cmd_code_t           code;

  assign slot    = pos[KW_POS_W-1:0];
  assign pos_low = ((pos >> KW_POS_W) == '0);

  // Drop a keyword whose character at this position differs
  always_comb begin
    alive_nxt = alive;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos_low && ({1'b0, slot} < KW_LEN[k]) && (rx_byte != KW_TEXT[k][slot])) begin
        alive_nxt[k] = 1'b0;
      end
    end
  end

  // First surviving keyword in table order wins
  always_comb begin
    code = CMD_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (alive[k]) begin
        code = cmd_code_t'(k[2:0]);
      end
    end
  end

  assign status = '{alive_nxt: alive_nxt, code: code};

endmodule

`default_nettype wire

// ===== rtl/core/at_command_line_classifier.sv =====
// ----------------------------------------------------------------------------
// at_command_line_classifier
// Byte-serial classifier for plus-prefixed command lines.
//
//   channel  dir  payload                                    accepted when
//   in_ch    in   rx_byte[7:0]                               valid && ready
//   out_ch   out  command_code[2:0], reply_ok, line_length   valid && ready
//
// One byte is taken every cycle while in_ch.ready is high; a carriage return yields
// its result in the output register in the cycle after acceptance. The only path is the keyword
// compare and line state update between the byte and the result register.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
// Synchronous active-low reset returns to idle with an unknown last result.
// ----------------------------------------------------------------------------
`default_nettype none

module at_command_line_classifier
  import acl_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  acl_in_if.sink     in_ch,
  acl_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic              receiving_r;
  logic [CNT_W-1:0]  count_r;
  kw_mask_t          alive_r;
  cmd_code_t         last_code_r;
  logic [LEN_W-1:0]  last_len_r;

  logic              out_valid_r;
  cmd_code_t         out_code_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              accept;
  logic              is_plus;
  logic              is_cr;
  logic              room;
  logic [LEN_W-1:0]  len_sat;
  acl_match_t        match;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_plus     = (in_ch.rx_byte == BYTE_PLUS);
  assign is_cr       = (in_ch.rx_byte == BYTE_CR);
  assign room        = (count_r < CNT_W'(BUFFER_DEPTH));

  // Saturate the stored count to the length field
  assign len_sat = (32'(count_r) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(count_r);

  acl_matcher #(
    .CNT_W (CNT_W)
  ) u_matcher (
    .pos     (count_r),
    .rx_byte (in_ch.rx_byte),
    .alive   (alive_r),
    .status  (match)
  );

  // Line state: restart on plus, close on carriage return, count stored bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      count_r     <= '0;
      alive_r     <= '0;
      last_code_r <= CMD_UNKNOWN;
      last_len_r  <= '0;
    end else if (accept) begin
      if (is_plus) begin
        receiving_r <= 1'b1;
        count_r     <= CNT_W'(1);
        alive_r     <= '1;
      end else if (is_cr) begin
        if (receiving_r) begin
          last_code_r <= match.code;
          last_len_r  <= len_sat;
          receiving_r <= 1'b0;
        end
      end else if (receiving_r && room) begin
        alive_r <= match.alive_nxt;
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Result register: load on carriage return, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && is_cr) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_cr) begin
      out_code_r <= receiving_r ? match.code : last_code_r;
      out_len_r  <= receiving_r ? len_sat : last_len_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.command_code = out_code_r;
  assign out_ch.reply_ok     = (out_code_r != CMD_UNKNOWN);
  assign out_ch.line_length  = out_len_r;

endmodule

`default_nettype wire

// ===== rtl/core/acl_checker.sv =====
// ----------------------------------------------------------------------------
// acl_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_checker
  import acl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_command_code,
  input wire logic       out_reply_ok,
  input wire logic [8:0] out_line_length
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_code)
      && $stable(out_reply_ok) && $stable(out_line_length))
    else $error("stalled result changed");

  // A new result follows only an accepted carriage return
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(($past(out_valid) && !$past(out_ready)))
      |-> $past(in_valid && in_ready && (in_rx_byte == BYTE_CR)))
    else $error("result without carriage return");

  // Reply flag agrees with the command code
  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply_ok == (out_command_code != CMD_UNKNOWN)))
    else $error("reply flag mismatch");

  // A zero-length line can only be unknown
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_line_length == 9'd0) |-> (out_command_code == CMD_UNKNOWN))
    else $error("known command with empty line");

endmodule

bind at_command_line_classifier acl_checker u_acl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_rx_byte       (in_ch.rx_byte),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_command_code (out_ch.command_code),
  .out_reply_ok     (out_ch.reply_ok),
  .out_line_length  (out_ch.line_length)
);

`default_nettype wire
